// ----- rtl/rldi_pkg.sv -----
// Package for the recent-list block: field widths, the entry layout and the operation codes.
// It depends on nothing; every other file of the block imports it.
`default_nettype none

package rldi_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 64;
  localparam int TIME_W       = 48;
  localparam int TAG_W        = 16;
  localparam int POS_W        = 6;
  localparam int IN_DATA_W    = KEY_W + TIME_W + TAG_W;
  localparam int OUT_DATA_W   = ((IN_DATA_W + POS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - IN_DATA_W - POS_W;

  typedef enum logic {
    OP_CURRENT = 1'b0,
    OP_OLDER   = 1'b1
  } op_t;

  // The key sits in the lowest bits, as on the stream ports.
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] stamp;
    logic [KEY_W-1:0]  key;
  } entry_t;

  typedef struct packed {
    logic key_eq;
    logic time_lt;
  } cmp_res_t;

endpackage

`default_nettype wire

// ----- rtl/rldi_mem.sv -----
// Entry store of the recent list: one write port and one registered read port.
// It depends on rldi_pkg for the entry layout.
`default_nettype none

module rldi_mem #(
  parameter int DEPTH = rldi_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  rldi_pkg::entry_t         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output rldi_pkg::entry_t         rdata
);
  import rldi_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/rldi_cmp.sv -----
// Shared compare unit: checks a stored entry against the held item for key equality and age.
// It depends on rldi_pkg for the entry layout and the result struct.
`default_nettype none

module rldi_cmp (
  input  rldi_pkg::entry_t   stored,
  input  rldi_pkg::entry_t   item,
  output rldi_pkg::cmp_res_t res
);
  import rldi_pkg::*;

  always_comb begin
    res.key_eq  = (stored.key == item.key);
    res.time_lt = (stored.stamp < item.stamp);
  end

endmodule

`default_nettype wire

// ----- rtl/recent_list_dedupe_insert_top.sv -----
// Top level of the recent list: sequencer, entry store and compare unit.
// It depends on rldi_pkg, rldi_mem and rldi_cmp.
//
//   channel | direction | tdata (low bit up)               | tuser | tlast
//   in_     | slave     | clip_key, clip_time, clip_tag     | op    | -
//   out_    | master    | out_key, out_time, out_tag, pos.  | -     | last
//
// An item is searched by reading each stored entry in turn and is then decided on; each entry moved by
// one place takes a read state and a write state, the item is then written, and each emitted entry passes
// a read, a load and an output state, plus stalls. The single read port of the entry store sets this walk.
// Reset clears the entry count and the control state; the store itself is not cleared.
// The input is ready only while the block is idle; a stall on the output holds the list walk.
`default_nettype none

module recent_list_dedupe_insert_top #(
  parameter int CAPACITY = rldi_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rldi_pkg::IN_DATA_W-1:0]  in_tdata,   // clip_key, clip_time, clip_tag
  input  logic [0:0]                      in_tuser,   // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rldi_pkg::OUT_DATA_W-1:0] out_tdata,  // out_key, out_time, out_tag, position
  output logic                            out_tlast
);
  import rldi_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_M1 = CNT_W'(CAPACITY - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_INS,
    S_EM_RD,
    S_EM_LD,
    S_EM_OUT
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  newcnt_r;
  op_t               op_r;
  entry_t            new_r;
  logic [CNT_W-1:0]  scan_r;
  logic              pend_r;
  logic [IDX_W-1:0]  pend_idx_r;
  logic              found_r;
  logic [IDX_W-1:0]  fidx_r;
  logic [TIME_W-1:0] ftime_r;
  logic [CNT_W-1:0]  at_r;
  logic              at_hit_r;
  logic [IDX_W-1:0]  lo_r;
  logic [IDX_W-1:0]  j_r;
  logic [IDX_W-1:0]  e_r;
  logic              out_valid_r;
  entry_t            out_ent_r;
  logic [IDX_W-1:0]  out_pos_r;
  logic              out_last_r;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  entry_t            mem_rdata;
  cmp_res_t          cmp_res;
  logic [CNT_W-1:0]  top_full;
  logic [CNT_W-1:0]  cnt_inc;

  rldi_mem #(
    .DEPTH(CAPACITY)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  rldi_cmp u_cmp (
    .stored(mem_rdata),
    .item  (new_r),
    .res   (cmp_res)
  );

  always_comb begin
    top_full = (count_r == CAP_C) ? CAP_M1 : count_r;
    cnt_inc  = (count_r == CAP_C) ? CAP_C : count_r + CNT_W'(1);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = j_r;
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    unique case (state_r)
      S_SRCH: begin
        mem_raddr = scan_r[IDX_W-1:0];
      end
      S_SH_RD: begin
        mem_raddr = j_r - IDX_W'(1);
      end
      S_SH_WR: begin
        mem_we = 1'b1;
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r;
        mem_wdata = new_r;
      end
      S_EM_RD: begin
        mem_raddr = e_r;
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r     <= op_t'(in_tuser[0]);
            new_r    <= entry_t'(in_tdata);
            scan_r   <= '0;
            pend_r   <= 1'b0;
            found_r  <= 1'b0;
            at_r     <= count_r;
            at_hit_r <= 1'b0;
            state_r  <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (pend_r) begin
            if (cmp_res.key_eq && !found_r) begin
              found_r <= 1'b1;
              fidx_r  <= pend_idx_r;
              ftime_r <= mem_rdata.stamp;
            end
            if (!at_hit_r && pend_idx_r != '0 && cmp_res.time_lt) begin
              at_hit_r <= 1'b1;
              at_r     <= CNT_W'(pend_idx_r);
            end
          end
          if (scan_r < count_r) begin
            pend_r     <= 1'b1;
            pend_idx_r <= scan_r[IDX_W-1:0];
            scan_r     <= scan_r + CNT_W'(1);
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              state_r <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (op_r == OP_CURRENT) begin
            if (found_r && fidx_r == '0 && new_r.stamp == '0) begin
              state_r <= S_IDLE;
            end else begin
              if (found_r && new_r.stamp == '0) begin
                new_r.stamp <= ftime_r;
              end
              lo_r     <= '0;
              j_r      <= found_r ? fidx_r : top_full[IDX_W-1:0];
              newcnt_r <= found_r ? count_r : cnt_inc;
              state_r  <= S_SH_RD;
            end
          end else begin
            if (found_r) begin
              state_r <= S_IDLE;
            end else if (at_r == CAP_C) begin
              e_r     <= '0;
              state_r <= S_EM_RD;
            end else begin
              lo_r     <= at_r[IDX_W-1:0];
              j_r      <= top_full[IDX_W-1:0];
              newcnt_r <= cnt_inc;
              state_r  <= S_SH_RD;
            end
          end
        end
        S_SH_RD: begin
          state_r <= (j_r == lo_r) ? S_INS : S_SH_WR;
        end
        S_SH_WR: begin
          j_r     <= j_r - IDX_W'(1);
          state_r <= S_SH_RD;
        end
        S_INS: begin
          count_r <= newcnt_r;
          e_r     <= '0;
          state_r <= S_EM_RD;
        end
        S_EM_RD: begin
          state_r <= S_EM_LD;
        end
        S_EM_LD: begin
          out_ent_r   <= mem_rdata;
          out_pos_r   <= e_r;
          out_last_r  <= (CNT_W'(e_r) + CNT_W'(1) == count_r);
          out_valid_r <= 1'b1;
          state_r     <= S_EM_OUT;
        end
        S_EM_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              e_r     <= e_r + IDX_W'(1);
              state_r <= S_EM_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, POS_W'(out_pos_r), out_ent_r};
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count exceeds the capacity");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is still shown");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("block not idle after the final entry");

  a_pos_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (CNT_W'(out_pos_r) < count_r))
    else $error("emitted position beyond the list");
`endif

endmodule

`default_nettype wire
